// ----- hdl/vwm_pkg.sv -----
package vwm_pkg;

  // window geometry
  localparam int unsigned WINDOW_MAX = 128;
  localparam int unsigned WIN_AW     = $clog2(WINDOW_MAX);
  localparam int unsigned LEN_W      = $clog2(WINDOW_MAX + 1);

  // field widths
  localparam int unsigned YAW_W  = 16;
  localparam int unsigned MEAN_W = 16;
  localparam int unsigned DEV_W  = 17;
  localparam int unsigned WL_W   = 8;
  localparam int unsigned TO_W   = 10;
  localparam int unsigned FILL_W = 8;

  // running sum holds up to WINDOW_MAX full-scale samples
  localparam int unsigned SUM_W     = YAW_W + WIN_AW + 1;
  localparam int unsigned MAG_W     = SUM_W - 1;
  localparam int unsigned DIV_CNT_W = $clog2(MAG_W);

  // stream widths
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 48;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

  localparam logic [WL_W-1:0] WL_RESET    = 8'd50;
  localparam logic [TO_W-1:0] TO_RESET    = 10'd200;
  localparam logic [TO_W-1:0] SILENCE_MAX = 10'd1023;

  // request kinds
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_FRAME = 1'b1;

  // divide request from the sequencer
  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [LEN_W-1:0]        divisor;
  } div_req_t;

  // window length clamped to 1..WINDOW_MAX
  function automatic logic [LEN_W-1:0] eff_len(input logic [WL_W-1:0] wl);
    logic [LEN_W-1:0] len;
    if (wl == '0) begin
      len = LEN_W'(1);
    end else if (int'(wl) > int'(WINDOW_MAX)) begin
      len = LEN_W'(WINDOW_MAX);
    end else begin
      len = LEN_W'(wl);
    end
    return len;
  endfunction

  // zero timeout behaves as one
  function automatic logic [TO_W-1:0] eff_timeout(input logic [TO_W-1:0] to);
    logic [TO_W-1:0] t;
    t = (to == '0) ? TO_W'(1) : to;
    return t;
  endfunction

endpackage

// ----- hdl/vwm_ram.sv -----
module vwm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/vwm_div.sv -----
module vwm_div
  import vwm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  div_req_t                 req_i,
  output logic                     done_o,
  output logic signed [MEAN_W-1:0] quot_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 neg_q, neg_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0]     quo_q, quo_d;
  logic [LEN_W-1:0]     rem_q, rem_d;
  logic [LEN_W-1:0]     dvs_q, dvs_d;
  logic [MAG_W-1:0]     mag;
  logic [LEN_W:0]       rem_sh;
  logic                 ge;
  logic [MEAN_W-1:0]    qmag;

  // magnitude of the dividend
  assign mag = req_i.dividend[SUM_W-1] ? MAG_W'(-req_i.dividend) : MAG_W'(req_i.dividend);

  // one restoring step
  assign rem_sh = {rem_q, quo_q[MAG_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      neg_d  = req_i.dividend[SUM_W-1];
      cnt_d  = DIV_CNT_W'(MAG_W - 1);
      quo_d  = mag;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? LEN_W'(rem_sh - {1'b0, dvs_q}) : LEN_W'(rem_sh);
      quo_d = {quo_q[MAG_W-2:0], ge};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  // quotient truncated toward zero
  assign qmag   = quo_q[MEAN_W-1:0];
  assign quot_o = neg_q ? MEAN_W'(-qmag) : qmag;
  assign done_o = done_q;

  // a new divide is only started when the unit is free
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divide started while busy");

  // completion follows the last step exactly
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divide done without a running divide");

endmodule

// ----- hdl/vision_window_mean_tracker.sv -----
// Moving-average tracker for a vision target's yaw angle.
// Input stream: s_axis_tuser carries the kind (timer tick or vision frame) and
// the target-found flag, s_axis_tdata the signed Q8.8 yaw angle. Each item
// gives exactly one result on the output stream: window mean, deviation of the
// latest sample, tracking and link flags, and the number of samples held.
// Configuration: cfg_we_i writes register cfg_idx_i (0 window length, 1 timeout
// in ticks); writing the window length empties the window.
// Sequencing: a tick or a frame without a target goes from the idle state
// straight to the output state. A frame with a target runs a bit-serial divide
// of the window sum by the window length, one quotient bit per cycle over the
// 23-bit magnitude; when the window is full, the oldest sample is first read
// back from the sample RAM and replaced. s_axis_tready is high only while the
// sequencer is idle, so a new item is taken only once the previous one has
// left the sequencer. A finished result sits in an output register; a new
// item is taken while it waits, and the next result holds in the sequencer
// until the receiver takes the previous one.
// Reset empties the window, clears both flags and loads a window length of
// 50 and a timeout of 200 ticks. The sample RAM needs no clearing: the fill
// count decides which entries are live.
module vision_window_mean_tracker
  import vwm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // stream in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [15:0] yaw_angle
  input  logic [S_TUSER_W-1:0]  s_axis_tuser,   // [0] req_type, [1] target_found
  // stream out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [15:0] window_mean, [32:16] deviation,
                                                // [33] tracking, [34] link_alive,
                                                // [42:35] fill_count, [47:43] zero
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_DSTART = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_OUT    = 5'b10000
  } state_e;

  state_e                   state_q, state_d;
  logic [WL_W-1:0]          wl_q, wl_d;
  logic [TO_W-1:0]          to_q, to_d;
  logic [LEN_W-1:0]         filled_q, filled_d;
  logic [WIN_AW-1:0]        oldest_q, oldest_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [TO_W-1:0]          silence_q, silence_d;
  logic signed [MEAN_W-1:0] mean_q, mean_d;
  logic signed [DEV_W-1:0]  dev_q, dev_d;
  logic                     track_q, track_d;
  logic                     alive_q, alive_d;
  logic signed [YAW_W-1:0]  sample_q, sample_d;
  logic                     m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0]     m_data_q, m_data_d;

  logic                     in_fire;
  logic                     req_type;
  logic                     target_found;
  logic signed [YAW_W-1:0]  yaw;
  logic [LEN_W-1:0]         len;
  logic [TO_W-1:0]          silence_inc;
  logic [LEN_W-1:0]         oldest_inc;
  logic                     clear_win;

  logic                     ram_we;
  logic [WIN_AW-1:0]        ram_waddr;
  logic [YAW_W-1:0]         ram_rdata;
  logic signed [YAW_W-1:0]  old_sample;

  div_req_t                 div_req;
  logic                     div_done;
  logic signed [MEAN_W-1:0] div_quot;

  assign req_type     = s_axis_tuser[0];
  assign target_found = s_axis_tuser[1];
  assign yaw          = s_axis_tdata[YAW_W-1:0];
  assign len          = eff_len(wl_q);
  assign silence_inc  = (silence_q == SILENCE_MAX) ? silence_q : silence_q + TO_W'(1);
  assign oldest_inc   = LEN_W'(oldest_q) + LEN_W'(1);
  assign old_sample   = ram_rdata;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // sample store
  vwm_ram #(
    .WIDTH (YAW_W),
    .DEPTH (WINDOW_MAX)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (sample_d),
    .raddr_i (oldest_q),
    .rdata_o (ram_rdata)
  );

  // bit-serial divider
  vwm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // sequencer and window update
  always_comb begin
    state_d   = state_q;
    wl_d      = wl_q;
    to_d      = to_q;
    filled_d  = filled_q;
    oldest_d  = oldest_q;
    sum_d     = sum_q;
    silence_d = silence_q;
    mean_d    = mean_q;
    dev_d     = dev_q;
    track_d   = track_q;
    alive_d   = alive_q;
    sample_d  = sample_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    clear_win = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = oldest_q;
    div_req   = '{start: 1'b0, dividend: sum_q, divisor: len};

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (req_type == REQ_FRAME) begin
            silence_d = '0;
            alive_d   = 1'b1;
            if (!target_found) begin
              clear_win = 1'b1;
              track_d   = 1'b0;
              state_d   = ST_OUT;
            end else begin
              track_d  = 1'b1;
              sample_d = yaw;
              if (filled_q < len) begin
                // window still filling
                ram_we    = 1'b1;
                ram_waddr = filled_q[WIN_AW-1:0];
                filled_d  = filled_q + LEN_W'(1);
                sum_d     = sum_q + SUM_W'(yaw);
                state_d   = ST_DSTART;
              end else begin
                state_d = ST_READ;
              end
            end
          end else begin
            silence_d = silence_inc;
            if (silence_inc >= eff_timeout(to_q)) begin
              clear_win = 1'b1;
              track_d   = 1'b0;
              alive_d   = 1'b0;
            end
            state_d = ST_OUT;
          end
        end
      end
      ST_READ: begin
        // replace the oldest sample
        ram_we    = 1'b1;
        ram_waddr = oldest_q;
        sum_d     = sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
        oldest_d  = (oldest_inc >= len) ? '0 : oldest_inc[WIN_AW-1:0];
        state_d   = ST_DSTART;
      end
      ST_DSTART: begin
        div_req.start = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          mean_d  = div_quot;
          dev_d   = DEV_W'(sample_q) - DEV_W'(div_quot);
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {5'b0, FILL_W'(filled_q), alive_q, track_q, dev_q, mean_q};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // configuration writes; the host must issue them only while idle, the block does not enforce it
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_LENGTH: begin
          wl_d      = cfg_data_i[WL_W-1:0];
          clear_win = 1'b1;
        end
        REG_TIMEOUT_TICKS: begin
          to_d = cfg_data_i[TO_W-1:0];
        end
        default: begin
          to_d = to_q;
        end
      endcase
    end

    if (clear_win) begin
      filled_d = '0;
      oldest_d = '0;
      sum_d    = '0;
      mean_d   = '0;
      dev_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wl_q      <= WL_RESET;
      to_q      <= TO_RESET;
      filled_q  <= '0;
      oldest_q  <= '0;
      sum_q     <= '0;
      silence_q <= '0;
      mean_q    <= '0;
      dev_q     <= '0;
      track_q   <= 1'b0;
      alive_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wl_q      <= wl_d;
      to_q      <= to_d;
      filled_q  <= filled_d;
      oldest_q  <= oldest_d;
      sum_q     <= sum_d;
      silence_q <= silence_d;
      mean_q    <= mean_d;
      dev_q     <= dev_d;
      track_q   <= track_d;
      alive_q   <= alive_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // fill count never passes the window length
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= len)
    else $error("fill count above window length");

  // oldest slot stays inside the window
  a_oldest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(oldest_q) < len)
    else $error("oldest slot outside window");

  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("item accepted while busy");

  // divider completes only while the sequencer waits on it
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divide finished outside divide state");

endmodule

// ----- tb/vision_window_mean_tracker_tb.sv -----
module vision_window_mean_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vwm_pkg::*;

  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned QUIET_LIMIT = 1023;

  // one result item as it leaves the block
  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [DEV_W-1:0]  deviation;
    logic              tracking;
    logic              link_alive;
    logic [FILL_W-1:0] fill;
  } track_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;   // [15:0] yaw_angle
  logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;   // [0] req_type, [1] target_found
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;         // [15:0] window_mean, [32:16] deviation,
                                               // [33] tracking, [34] link_alive,
                                               // [42:35] fill_count
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // tracker state mirrored on the testbench side
  logic signed [YAW_W-1:0] yaw_ring [WINDOW_MAX];
  int unsigned             ring_fill;
  int unsigned             ring_oldest;
  int                      ring_sum;
  int unsigned             silent_ticks;
  int                      last_mean;
  int                      last_dev;
  logic                    tracking_now;
  logic                    link_now;
  logic [WL_W-1:0]         win_len_reg;
  logic [TO_W-1:0]         timeout_reg;

  track_result_t pending_tracks [$];
  int unsigned   mismatches;

  // flow control shared by sender and receiver
  bit          steady_flow;
  int unsigned hold_asked;
  int unsigned hold_taken;
  int unsigned hold_left;
  int unsigned stall_left;

  vision_window_mean_tracker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #15ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned eff_window();
    if (win_len_reg == '0) return 1;
    if (32'(win_len_reg) > WINDOW_MAX) return WINDOW_MAX;
    return 32'(win_len_reg);
  endfunction

  function automatic int unsigned eff_timeout_ticks();
    return (timeout_reg == '0) ? 1 : 32'(timeout_reg);
  endfunction

  function automatic void empty_window();
    foreach (yaw_ring[i]) yaw_ring[i] = '0;
    ring_fill   = 0;
    ring_oldest = 0;
    ring_sum    = 0;
    last_mean   = 0;
    last_dev    = 0;
  endfunction

  // state update and result for one accepted item
  function automatic track_result_t track_yaw(logic kind, logic found, logic [YAW_W-1:0] yaw);
    track_result_t res;
    int unsigned   len;
    int unsigned   slot;
    int            sample;
    sample = int'($signed(yaw));
    if (kind == REQ_FRAME) begin
      if (!found) begin
        empty_window();
        tracking_now = 1'b0;
      end else begin
        tracking_now = 1'b1;
        len = eff_window();
        if (ring_fill < len) begin
          yaw_ring[ring_fill] = yaw;
          ring_fill++;
        end else begin
          // window full: newest replaces oldest
          slot = (ring_oldest < len) ? ring_oldest : 0;
          ring_sum -= int'(yaw_ring[slot]);
          yaw_ring[slot] = yaw;
          slot++;
          ring_oldest = (slot >= len) ? 0 : slot;
        end
        ring_sum += sample;
        last_mean = ring_sum / int'(len);
        last_dev  = sample - last_mean;
      end
      silent_ticks = 0;
      link_now     = 1'b1;
    end else begin
      // tick: count silence, drop everything on timeout
      if (silent_ticks < QUIET_LIMIT) silent_ticks++;
      if (silent_ticks >= eff_timeout_ticks()) begin
        empty_window();
        tracking_now = 1'b0;
        link_now     = 1'b0;
      end
    end
    res.mean       = last_mean[MEAN_W-1:0];
    res.deviation  = last_dev[DEV_W-1:0];
    res.tracking   = tracking_now;
    res.link_alive = link_now;
    res.fill       = ring_fill[FILL_W-1:0];
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin : result_check
    track_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_tracks.size() == 0) begin
        $error("result item with nothing outstanding: tdata 0x%0h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_tracks.pop_front();
        check_field("window_mean", 32'(want.mean), 32'(m_axis_tdata[15:0]));
        check_field("deviation", 32'(want.deviation), 32'(m_axis_tdata[32:16]));
        check_field("tracking", 32'(want.tracking), 32'(m_axis_tdata[33]));
        check_field("link_alive", 32'(want.link_alive), 32'(m_axis_tdata[34]));
        check_field("fill_count", 32'(want.fill), 32'(m_axis_tdata[42:35]));
      end
    end
  end

  // receiver: random stalls, plus a long hold on request
  always @(negedge clk_i) begin
    if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left  = LONG_HOLD;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (steady_flow) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (stall_left == 0 && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // offer one item, predict its result once taken
  task automatic send_item(input logic kind, input logic found, input logic [YAW_W-1:0] yaw);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = S_TDATA_W'($urandom);
      s_axis_tuser  = S_TUSER_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = yaw;
    s_axis_tuser  = {found, kind};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_tracks.push_back(track_yaw(kind, found, yaw));
    @(negedge clk_i);
  endtask

  // block idle: no item offered and every result back
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending_tracks.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    cfg_data_i = CFG_DATA_W'($urandom);
    if (idx == REG_WINDOW_LENGTH) begin
      win_len_reg = value[WL_W-1:0];
      empty_window();
    end else if (idx == REG_TIMEOUT_TICKS) begin
      timeout_reg = value[TO_W-1:0];
    end
    @(negedge clk_i);
  endtask

  function automatic logic [YAW_W-1:0] pick_yaw();
    int unsigned roll;
    logic [YAW_W-1:0] picks [5];
    picks = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
    roll = $urandom_range(0, 99);
    if (roll < 70) return YAW_W'($urandom);
    if (roll < 85) return picks[$urandom_range(0, 4)];
    return YAW_W'($urandom_range(0, 600) - 300);
  endfunction

  // field extremes, ignored fields on ticks, frames with and without target
  task automatic test_directed_items();
    steady_flow = 1'b0;
    send_item(REQ_TICK, 1'b1, 16'h5A5A);
    send_item(REQ_FRAME, 1'b0, 16'h1234);
    send_item(REQ_FRAME, 1'b1, 16'h7FFF);
    send_item(REQ_FRAME, 1'b1, 16'h8000);
    send_item(REQ_FRAME, 1'b1, 16'h0000);
    send_item(REQ_FRAME, 1'b1, 16'hFFFF);
    send_item(REQ_FRAME, 1'b1, 16'h0001);
    send_item(REQ_FRAME, 1'b1, 16'h8000);
    send_item(REQ_TICK, 1'b1, 16'h7FFF);
    send_item(REQ_TICK, 1'b0, 16'h8000);
    send_item(REQ_FRAME, 1'b1, YAW_W'($urandom));
    send_item(REQ_FRAME, 1'b0, 16'hFFFF);
    send_item(REQ_FRAME, 1'b1, 16'h8000);
    send_item(REQ_TICK, 1'b0, YAW_W'($urandom));
  endtask

  // short, zero, full and oversized windows, sums at both extremes
  task automatic test_window_lengths();
    logic [WL_W-1:0] codes [7];
    codes = '{8'd1, 8'd2, 8'd3, 8'd0, 8'd128, 8'd129, 8'd255};
    foreach (codes[c]) begin
      write_reg(REG_WINDOW_LENGTH, {2'($urandom), codes[c]});
      if (codes[c] == 8'd128) begin
        repeat (WINDOW_MAX) send_item(REQ_FRAME, 1'b1, 16'h7FFF);
        repeat (WINDOW_MAX) send_item(REQ_FRAME, 1'b1, 16'h8000);
        repeat (8) send_item(REQ_FRAME, 1'b1, pick_yaw());
      end else begin
        repeat (5) send_item(REQ_FRAME, 1'b1, pick_yaw());
        send_item(REQ_TICK, 1'($urandom), YAW_W'($urandom));
      end
    end
  endtask

  // zero timeout, one, a small one, and silence saturating at the top
  task automatic test_timeouts();
    write_reg(REG_WINDOW_LENGTH, 10'd4);
    write_reg(REG_TIMEOUT_TICKS, 10'd0);
    send_item(REQ_FRAME, 1'b1, pick_yaw());
    send_item(REQ_TICK, 1'b1, YAW_W'($urandom));
    send_item(REQ_TICK, 1'b0, YAW_W'($urandom));
    send_item(REQ_FRAME, 1'b1, pick_yaw());
    write_reg(REG_TIMEOUT_TICKS, 10'd1);
    send_item(REQ_TICK, 1'b0, YAW_W'($urandom));
    write_reg(REG_TIMEOUT_TICKS, 10'd4);
    send_item(REQ_FRAME, 1'b1, pick_yaw());
    send_item(REQ_FRAME, 1'b1, pick_yaw());
    repeat (5) send_item(REQ_TICK, 1'($urandom), YAW_W'($urandom));
    write_reg(REG_TIMEOUT_TICKS, 10'd1023);
    send_item(REQ_FRAME, 1'b1, pick_yaw());
    steady_flow = 1'b1;
    repeat (QUIET_LIMIT + 7) send_item(REQ_TICK, 1'($urandom), YAW_W'($urandom));
    steady_flow = 1'b0;
    send_item(REQ_FRAME, 1'b1, pick_yaw());
  endtask

  // a window length write empties the window but leaves the flags alone
  task automatic test_length_write_keeps_flags();
    write_reg(REG_TIMEOUT_TICKS, 10'd300);
    send_item(REQ_FRAME, 1'b1, 16'h4321);
    send_item(REQ_FRAME, 1'b1, 16'hC000);
    write_reg(REG_WINDOW_LENGTH, 10'd5);
    send_item(REQ_TICK, 1'b0, YAW_W'($urandom));
    send_item(REQ_FRAME, 1'b1, pick_yaw());
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    wait_idle();
    steady_flow = 1'b1;
    hold_asked++;
    repeat (12) send_item(REQ_FRAME, 1'b1, pick_yaw());
    send_item(REQ_TICK, 1'b0, YAW_W'($urandom));
    steady_flow = 1'b0;
  endtask

  // phases of random settings, mostly runs of target frames and tick runs
  task automatic test_random_traffic();
    int unsigned     sent;
    int unsigned     run;
    int unsigned     roll;
    logic [WL_W-1:0] len_code;
    logic [TO_W-1:0] to_code;
    repeat (6) begin
      roll = $urandom_range(0, 99);
      if (roll < 70)      len_code = WL_W'($urandom_range(1, 8));
      else if (roll < 90) len_code = WL_W'($urandom_range(9, 40));
      else                len_code = WL_W'($urandom);
      write_reg(REG_WINDOW_LENGTH, {2'($urandom), len_code});
      roll = $urandom_range(0, 99);
      if (roll < 70)      to_code = TO_W'($urandom_range(1, 25));
      else if (roll < 90) to_code = TO_W'($urandom_range(0, 100));
      else                to_code = TO_W'($urandom_range(100, 1023));
      write_reg(REG_TIMEOUT_TICKS, to_code);
      steady_flow = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < 50) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          run = $urandom_range(1, (2 * eff_window() + 2 > 40) ? 40 : 2 * eff_window() + 2);
          repeat (run) send_item(REQ_FRAME, 1'b1, pick_yaw());
        end else if (roll < 85) begin
          run = $urandom_range(1, (eff_timeout_ticks() + 2 > 30) ? 30 : eff_timeout_ticks() + 2);
          repeat (run) send_item(REQ_TICK, 1'($urandom), YAW_W'($urandom));
        end else if (roll < 92) begin
          run = 1;
          send_item(REQ_FRAME, 1'b0, YAW_W'($urandom));
        end else begin
          run = 1;
          send_item(1'($urandom), 1'($urandom), YAW_W'($urandom));
        end
        sent += run;
      end
    end
    steady_flow = 1'b0;
  endtask

  // main sequence
  initial begin
    mismatches   = 0;
    hold_asked   = 0;
    hold_taken   = 0;
    hold_left    = 0;
    stall_left   = 0;
    steady_flow  = 1'b0;
    win_len_reg  = WL_RESET;
    timeout_reg  = TO_RESET;
    silent_ticks = 0;
    tracking_now = 1'b0;
    link_now     = 1'b0;
    empty_window();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_items();
    test_window_lengths();
    test_timeouts();
    test_length_write_keeps_flags();
    test_backpressure();
    test_random_traffic();

    s_axis_tvalid = 1'b0;
    while (pending_tracks.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_tracks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/vwm_pkg.sv
hdl/vwm_ram.sv
hdl/vwm_div.sv
hdl/vision_window_mean_tracker.sv
tb/vision_window_mean_tracker_tb.sv
